// ===== sv/rea_pkg.sv =====
// Shared constants, field widths, state encoding and the multiplier control struct for the
// rotary encoder acceleration block. No dependencies; every other file imports it.
package rea_pkg;

    // Field widths
    localparam int VALUE_W   = 32;
    localparam int STEP_W    = 31;
    localparam int DET_W     = 30;
    localparam int MOVE_W    = 33;
    localparam int RATIO_W   = 5;
    localparam int GAP_W     = 10;
    localparam int DELTA_W   = DET_W + 1;
    localparam int SUM_W     = 63;

    // Item commands
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Configuration port
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 4;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_MIN   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_RATIO = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_GAP   = 2'd3;

    localparam logic [VALUE_W-1:0] MIN_RST   = 32'sd0;
    localparam logic [STEP_W-1:0]  MAX_RST   = 31'd10000;
    localparam logic [RATIO_W-1:0] RATIO_RST = 5'd5;
    localparam logic [GAP_W-1:0]   GAP_RST   = 10'd10;

    // Serial multiplier: one multiplier bit per cycle
    localparam int MUL_W     = 31;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int CNT_W     = 5;
    localparam int GPROD_W   = GAP_W + STEP_W;
    localparam int RPROD_W   = RATIO_W + STEP_W;

    localparam logic [CNT_W-1:0] LEN_FULL  = CNT_W'(MUL_W);
    localparam logic [CNT_W-1:0] LEN_GAP   = CNT_W'(GAP_W);
    localparam logic [CNT_W-1:0] LEN_RATIO = CNT_W'(RATIO_W);

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] len;
    } mul_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SMP_DELTA,
        ST_SMP_GO,
        ST_SMP_MUL,
        ST_SMP_SUM,
        ST_SMP_CLAMP,
        ST_TCK_MOVE,
        ST_TCK_GO,
        ST_TCK_GAP,
        ST_TCK_GROW_CHK,
        ST_TCK_GROW,
        ST_TCK_SHRINK_CHK,
        ST_TCK_DIV,
        ST_DONE
    } state_t;

endpackage

// ===== sv/rea_sermul.sv =====
// Shift-add serial multiplier, one multiplier bit per cycle, LSB first.
// Depends on rea_pkg (widths, mul_ctl_t).
module rea_sermul (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rea_pkg::mul_ctl_t          ctl,
    input  logic [rea_pkg::MUL_W-1:0]  a,
    input  logic [rea_pkg::MUL_W-1:0]  b,
    output logic                       done,
    output logic [rea_pkg::PROD_W-1:0] prod
);
    import rea_pkg::*;

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [MUL_W-1:0] a_reg, a_next;
    logic [MUL_W-1:0] b_reg, b_next;
    logic [PROD_W-1:0] p_reg, p_next;
    logic [MUL_W:0]   part_sum;

    // Partial product into the upper half, then shift the whole product right
    assign part_sum = {1'b0, p_reg[PROD_W-1:MUL_W]} + (b_reg[0] ? {1'b0, a_reg} : '0);

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        p_next    = p_reg;
        if (ctl.start)
        begin
            run_next = 1'b1;
            cnt_next = ctl.len;
            a_next   = a;
            b_next   = b;
            p_next   = '0;
        end
        else if (run_reg)
        begin
            p_next   = {part_sum, p_reg[MUL_W-1:1]};
            b_next   = {1'b0, b_reg[MUL_W-1:1]};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operands and product
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        p_reg <= p_next;
    end

    assign done = done_reg;
    assign prod = p_reg;

endmodule

// ===== sv/rea_serdiv.sv =====
// Restoring serial divider of the step by the ratio, one quotient bit per cycle.
// Depends on rea_pkg (widths).
module rea_serdiv (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rea_pkg::STEP_W-1:0]  dividend,
    input  logic [rea_pkg::RATIO_W-1:0] divisor,
    output logic                        done,
    output logic [rea_pkg::STEP_W-1:0]  quotient
);
    import rea_pkg::*;

    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [RATIO_W-1:0] rem_reg, rem_next;
    logic [RATIO_W-1:0] dvs_reg, dvs_next;
    logic [STEP_W-1:0]  quo_reg, quo_next;
    logic [RATIO_W:0]   trial;
    logic [RATIO_W:0]   diff;
    logic               ge;

    // One restoring step: bring down the next dividend bit, subtract if it fits
    assign trial = {rem_reg, quo_reg[STEP_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_W'(STEP_W);
            rem_next = '0;
            dvs_next = divisor;
            quo_next = dividend;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[RATIO_W-1:0] : trial[RATIO_W-1:0];
            quo_next = {quo_reg[STEP_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/rotary_encoder_acceleration.sv =====
// Rotary encoder acceleration: detent tracking, accelerated clamped value and
// step adaptation. Depends on rea_pkg, rea_sermul and rea_serdiv.
//
// Usage: items arrive on the item channel (cmd, raw_count) under valid/ready.
// cmd 0 is a position sample, cmd 1 an interval tick. Each item gives exactly
// one result beat (value, step_size, detent_pos, interval_move) on the result
// channel. One item is in work at a time; item_ready is high only when idle.
// A sample whose detent is unchanged passes the delta and go states to the
// final state; a sample that moves the value runs the serial multiplier (one
// step bit per cycle), then the sum and clamp states. A tick runs it for the
// gap product, again for the ratio product if the step grows, and then the
// divider if the step shrinks. A finished result sits in the output register,
// so a new item may be accepted while result_ready is low; the block then
// waits in its final state until the output register is free. Reset: value 0,
// step 1, detent and reference values -1, registers at their defaults (min 0,
// max 10000, ratio 5, gap 10), no result pending. The user must write the
// registers through the APB port only while the block is idle; it is not enforced.
module rotary_encoder_acceleration (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rea_pkg::ADDR_W-1:0]         paddr,
    input  logic [rea_pkg::DATA_W-1:0]         pwdata,
    output logic [rea_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic                               cmd,
    input  logic signed [rea_pkg::VALUE_W-1:0] raw_count,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic signed [rea_pkg::VALUE_W-1:0] value,
    output logic [rea_pkg::STEP_W-1:0]         step_size,
    output logic signed [rea_pkg::DET_W-1:0]   detent_pos,
    output logic signed [rea_pkg::MOVE_W-1:0]  interval_move
);
    import rea_pkg::*;

    // Configuration
    logic signed [VALUE_W-1:0] min_reg;
    logic [STEP_W-1:0]         max_reg;
    logic [RATIO_W-1:0]        ratio_reg;
    logic [GAP_W-1:0]          gap_reg;
    logic                      cfg_wr;
    logic [REG_IDX_W-1:0]      cfg_idx;

    // Block state
    state_t                    state_reg, state_next;
    logic signed [VALUE_W-1:0] out_value_reg, out_value_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic signed [DET_W-1:0]   last_det_reg, last_det_next;
    logic signed [VALUE_W-1:0] vac_reg, vac_next;
    logic signed [VALUE_W-1:0] vat_reg, vat_next;

    // Per-item working registers
    logic                      cmd_reg, cmd_next;
    logic signed [DET_W-1:0]   det_reg, det_next;
    logic signed [DELTA_W-1:0] delta_reg, delta_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [MOVE_W-1:0]  move_reg, move_next;
    logic [MOVE_W-1:0]         mag_reg, mag_next;

    // Result register
    logic                      res_valid_reg, res_valid_next;
    logic signed [VALUE_W-1:0] res_value_reg, res_value_next;
    logic [STEP_W-1:0]         res_step_reg, res_step_next;
    logic signed [DET_W-1:0]   res_det_reg, res_det_next;
    logic signed [MOVE_W-1:0]  res_move_reg, res_move_next;

    // Control and helpers
    logic                      item_fire;
    logic                      res_load;
    mul_ctl_t                  mul_ctl;
    logic [MUL_W-1:0]          mul_a;
    logic [MUL_W-1:0]          mul_b;
    logic                      mul_done;
    logic [PROD_W-1:0]         mul_prod;
    logic                      div_start;
    logic                      div_done;
    logic [STEP_W-1:0]         div_quo;
    logic [RATIO_W-1:0]        r_eff;
    logic [STEP_W-1:0]         cap;
    logic                      det_fix;
    logic [DET_W-1:0]          det_in;
    logic [DELTA_W-1:0]        delta_mag;
    logic [GPROD_W-1:0]        gap_prod;
    logic [RPROD_W-1:0]        grow_prod;
    logic                      grow;
    logic                      shrink;
    logic signed [SUM_W-1:0]   out_ext;
    logic signed [SUM_W-1:0]   prod_ext;
    logic signed [SUM_W-1:0]   min_ext;
    logic signed [SUM_W-1:0]   max_ext;
    logic                      clamp_lo;
    logic                      clamp_hi;
    logic                      min_gt_max;

    // APB port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= MIN_RST;
            max_reg   <= MAX_RST;
            ratio_reg <= RATIO_RST;
            gap_reg   <= GAP_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_MIN:   min_reg   <= pwdata;
                REG_MAX:   max_reg   <= pwdata[STEP_W-1:0];
                REG_RATIO: ratio_reg <= pwdata[RATIO_W-1:0];
                REG_GAP:   gap_reg   <= pwdata[GAP_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_MIN:   prdata = min_reg;
            REG_MAX:   prdata = {{(DATA_W-STEP_W){1'b0}}, max_reg};
            REG_RATIO: prdata = {{(DATA_W-RATIO_W){1'b0}}, ratio_reg};
            REG_GAP:   prdata = {{(DATA_W-GAP_W){1'b0}}, gap_reg};
            default:   prdata = '0;
        endcase
    end

    // Ratio zero acts as one; max zero caps the step at one
    assign r_eff = (ratio_reg == '0) ? RATIO_W'(1) : ratio_reg;
    assign cap   = (max_reg == '0) ? STEP_W'(1) : max_reg;

    // Detent: raw count / 4, truncated toward zero
    assign det_fix = raw_count[VALUE_W-1] && (raw_count[1:0] != 2'b00);
    assign det_in  = raw_count[VALUE_W-1:2] + DET_W'(det_fix);

    assign item_fire = item_valid && item_ready;

    // Arithmetic helpers
    assign delta_mag = delta_reg[DELTA_W-1] ? (~delta_reg + DELTA_W'(1)) : delta_reg;
    assign gap_prod  = mul_prod[PROD_W-1 -: GPROD_W];
    assign grow_prod = mul_prod[PROD_W-1 -: RPROD_W];
    assign grow      = {{(GPROD_W-MOVE_W){1'b0}}, mag_reg} > gap_prod;
    assign shrink    = mag_reg < {{(MOVE_W-STEP_W){1'b0}}, step_reg};

    assign out_ext    = {{(SUM_W-VALUE_W){out_value_reg[VALUE_W-1]}}, out_value_reg};
    assign prod_ext   = {1'b0, mul_prod};
    assign min_ext    = {{(SUM_W-VALUE_W){min_reg[VALUE_W-1]}}, min_reg};
    assign max_ext    = {{(SUM_W-STEP_W){1'b0}}, max_reg};
    assign clamp_lo   = sum_reg < min_ext;
    assign min_gt_max = $signed({min_reg[VALUE_W-1], min_reg}) > $signed({2'b00, max_reg});
    assign clamp_hi   = clamp_lo ? min_gt_max : (sum_reg > max_ext);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (item_fire)
                    state_next = (cmd == CMD_TICK) ? ST_TCK_MOVE : ST_SMP_DELTA;
            ST_SMP_DELTA:      state_next = ST_SMP_GO;
            ST_SMP_GO:         state_next = (delta_reg == '0) ? ST_DONE : ST_SMP_MUL;
            ST_SMP_MUL:
                if (mul_done)
                    state_next = ST_SMP_SUM;
            ST_SMP_SUM:        state_next = ST_SMP_CLAMP;
            ST_SMP_CLAMP:      state_next = ST_DONE;
            ST_TCK_MOVE:       state_next = ST_TCK_GO;
            ST_TCK_GO:         state_next = ST_TCK_GAP;
            ST_TCK_GAP:
                if (mul_done)
                    state_next = ST_TCK_GROW_CHK;
            ST_TCK_GROW_CHK:   state_next = grow ? ST_TCK_GROW : ST_TCK_SHRINK_CHK;
            ST_TCK_GROW:
                if (mul_done)
                    state_next = ST_TCK_SHRINK_CHK;
            ST_TCK_SHRINK_CHK: state_next = shrink ? ST_TCK_DIV : ST_DONE;
            ST_TCK_DIV:
                if (div_done)
                    state_next = ST_DONE;
            ST_DONE:
                if (res_load)
                    state_next = ST_IDLE;
            default:           state_next = ST_IDLE;
        endcase
    end

    // Control outputs: handshake and unit starts
    always_comb
    begin
        item_ready    = 1'b0;
        res_load      = 1'b0;
        mul_ctl.start = 1'b0;
        mul_ctl.len   = LEN_FULL;
        mul_a         = step_reg;
        mul_b         = '0;
        div_start     = 1'b0;
        case (state_reg)
            ST_IDLE:
                item_ready = 1'b1;
            ST_SMP_GO:
            begin
                mul_ctl.start = (delta_reg != '0);
                mul_a         = delta_mag;
                mul_b         = step_reg;
            end
            ST_TCK_GO:
            begin
                mul_ctl.start = 1'b1;
                mul_ctl.len   = LEN_GAP;
                mul_b         = {{(MUL_W-GAP_W){1'b0}}, gap_reg};
            end
            ST_TCK_GROW_CHK:
            begin
                mul_ctl.start = grow;
                mul_ctl.len   = LEN_RATIO;
                mul_b         = {{(MUL_W-RATIO_W){1'b0}}, r_eff};
            end
            ST_TCK_SHRINK_CHK:
                div_start = shrink;
            ST_DONE:
                res_load = !res_valid_reg || result_ready;
            default: ;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        out_value_next = out_value_reg;
        step_next      = step_reg;
        last_det_next  = last_det_reg;
        vac_next       = vac_reg;
        vat_next       = vat_reg;
        cmd_next       = cmd_reg;
        det_next       = det_reg;
        delta_next     = delta_reg;
        sum_next       = sum_reg;
        move_next      = move_reg;
        mag_next       = mag_reg;
        res_value_next = res_value_reg;
        res_step_next  = res_step_reg;
        res_det_next   = res_det_reg;
        res_move_next  = res_move_reg;
        case (state_reg)
            ST_IDLE:
                if (item_fire)
                begin
                    cmd_next = cmd;
                    det_next = det_in;
                end
            ST_SMP_DELTA:
                delta_next = {det_reg[DET_W-1], det_reg}
                           - {last_det_reg[DET_W-1], last_det_reg};
            ST_SMP_SUM:
                sum_next = delta_reg[DELTA_W-1] ? (out_ext - prod_ext) : (out_ext + prod_ext);
            ST_SMP_CLAMP:
            begin
                if (clamp_hi)
                    out_value_next = {1'b0, max_reg};
                else if (clamp_lo)
                    out_value_next = min_reg;
                else
                    out_value_next = sum_reg[VALUE_W-1:0];
                if (clamp_lo || clamp_hi)
                    step_next = STEP_W'(1);
                last_det_next = det_reg;
                vac_next      = out_value_next;
            end
            ST_TCK_MOVE:
                move_next = {vac_reg[VALUE_W-1], vac_reg} - {vat_reg[VALUE_W-1], vat_reg};
            ST_TCK_GO:
            begin
                mag_next = move_reg[MOVE_W-1] ? (~move_reg + MOVE_W'(1)) : move_reg;
                vat_next = vac_reg;
            end
            ST_TCK_GROW:
                if (mul_done)
                    step_next = (grow_prod > {{(RPROD_W-STEP_W){1'b0}}, cap})
                              ? cap : grow_prod[STEP_W-1:0];
            ST_TCK_DIV:
                if (div_done)
                    step_next = (div_quo == '0) ? STEP_W'(1) : div_quo;
            ST_DONE:
                if (res_load)
                begin
                    res_value_next = out_value_reg;
                    res_step_next  = step_reg;
                    res_det_next   = last_det_reg;
                    res_move_next  = (cmd_reg == CMD_TICK) ? move_reg : '0;
                end
            default: ;
        endcase
    end

    // Result beat valid: set on load, cleared when taken
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
            res_valid_next = 1'b1;
        else if (result_ready)
            res_valid_next = 1'b0;
    end

    // Control and block state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            out_value_reg <= '0;
            step_reg      <= STEP_W'(1);
            last_det_reg  <= '1;
            vac_reg       <= '1;
            vat_reg       <= '1;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            out_value_reg <= out_value_next;
            step_reg      <= step_next;
            last_det_reg  <= last_det_next;
            vac_reg       <= vac_next;
            vat_reg       <= vat_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        det_reg       <= det_next;
        delta_reg     <= delta_next;
        sum_reg       <= sum_next;
        move_reg      <= move_next;
        mag_reg       <= mag_next;
        res_value_reg <= res_value_next;
        res_step_reg  <= res_step_next;
        res_det_reg   <= res_det_next;
        res_move_reg  <= res_move_next;
    end

    // Shared serial multiplier
    rea_sermul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mul_ctl),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // Step shrink divider
    rea_serdiv u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (step_reg),
        .divisor  (r_eff),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign result_valid  = res_valid_reg;
    assign value         = res_value_reg;
    assign step_size     = res_step_reg;
    assign detent_pos    = res_det_reg;
    assign interval_move = res_move_reg;

    // Checks
    a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg != '0)
        else $error("step dropped to zero");

    a_mul_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_SMP_MUL || state_reg == ST_TCK_GAP
                      || state_reg == ST_TCK_GROW))
        else $error("multiplier finished outside a wait state");

    a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_TCK_DIV))
        else $error("divider finished outside its wait state");

    a_clamp_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SMP_CLAMP && $signed(min_reg) <= $signed({1'b0, max_reg}))
        |=> ($signed(out_value_reg) >= $signed(min_reg)
             && $signed(out_value_reg) <= $signed({1'b0, max_reg})))
        else $error("clamped value outside bounds");

endmodule
